// ----- rtl/stepper_rate_ramp_timer_core_defines.svh -----
// assertion macros used by the stepper rate ramp timer core
`ifndef STEPPER_RATE_RAMP_TIMER_CORE_DEFINES_SVH
`define STEPPER_RATE_RAMP_TIMER_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, quiet in reset
`define SRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, quiet in reset
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/srr_pkg.sv -----
// shared types, constants and register codes of the stepper rate ramp timer
package srr_pkg;

	localparam int NUM_MOTORS = 4;
	localparam int MOTOR_W    = 2;
	localparam int RATE_W     = 20;
	localparam int PSC_W      = 11;

	// rotation request codes
	localparam logic [1:0] ROT_CW     = 2'd0;
	localparam logic [1:0] ROT_CCW    = 2'd1;
	localparam logic [1:0] ROT_RETAIN = 2'd2;
	localparam logic [1:0] ROT_TOGGLE = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_ACCEL_STEP   = 3'd0;
	localparam logic [2:0] CFG_DECEL_STEP   = 3'd1;
	localparam logic [2:0] CFG_NO_RAMP_MASK = 3'd2;
	localparam logic [2:0] CFG_INVERT_MASK  = 3'd3;
	localparam logic [2:0] CFG_TIMER_CLOCK  = 3'd4;

	// register reset values
	localparam logic [15:0] ACCEL_STEP_RST   = 16'd100;
	localparam logic [15:0] DECEL_STEP_RST   = 16'd100;
	localparam logic [3:0]  NO_RAMP_MASK_RST = 4'd0;
	localparam logic [3:0]  INVERT_MASK_RST  = 4'd12;
	localparam logic [31:0] TIMER_CLOCK_RST  = 32'd84000000;

	// decade prescaler thresholds and values
	localparam logic [RATE_W-1:0] THR_1000 = 20'd1000;
	localparam logic [RATE_W-1:0] THR_100  = 20'd100;
	localparam logic [RATE_W-1:0] THR_10   = 20'd10;
	localparam logic [RATE_W-1:0] THR_1    = 20'd1;
	localparam logic [PSC_W-1:0]  PSC_2    = 11'd2;
	localparam logic [PSC_W-1:0]  PSC_20   = 11'd20;
	localparam logic [PSC_W-1:0]  PSC_200  = 11'd200;
	localparam logic [PSC_W-1:0]  PSC_2000 = 11'd2000;

	typedef struct packed {
		logic              func;
		logic [1:0]        motor_index;
		logic [RATE_W-1:0] step_rate;
		logic [1:0]        rotation;
	} srr_item_t;

	typedef struct packed {
		logic [1:0]        out_motor;
		logic              dir_level;
		logic              drive_on;
		logic [PSC_W-1:0]  prescale_minus_one;
		logic [31:0]       reload_value;
		logic [30:0]       compare_value;
		logic [RATE_W-1:0] rate_now;
		logic              last;
	} srr_result_t;

	typedef struct packed {
		logic [15:0] accel_step;
		logic [15:0] decel_step;
		logic [3:0]  no_ramp_mask;
		logic [3:0]  invert_mask;
		logic [31:0] timer_clock;
	} srr_cfg_t;

	// classified command from the front end
	typedef struct packed {
		logic               is_tick;
		logic [MOTOR_W-1:0] motor;
		logic [RATE_W-1:0]  rate;
		logic [1:0]         rot;
	} srr_cmd_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} srr_div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} srr_div_rsp_t;

endpackage

// ----- rtl/srr_front.sv -----
// front end: takes input beats, applies direction inversion, queues commands
module srr_front import srr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  srr_item_t item,
	input  srr_cfg_t  cfg,
	output logic      cmd_valid,
	input  logic      cmd_ready,
	output srr_cmd_t  cmd
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	srr_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	srr_cmd_t         cls;
	logic             keep, wr_en, rd_en;

	// classify: ticks pass, set items get inversion, out-of-range motors drop
	always_comb begin
		cls.is_tick = item.func;
		cls.motor   = item.motor_index;
		cls.rate    = item.step_rate;
		cls.rot     = item.rotation;
		if (cfg.invert_mask[item.motor_index] &&
		    (item.rotation == ROT_CW || item.rotation == ROT_CCW)) begin
			cls.rot = {1'b0, ~item.rotation[0]};
		end
		keep = item.func || (int'(item.motor_index) < NUM_MOTORS);
	end

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign wr_en     = push && !full && keep;
	assign cmd_valid = (count_q != '0);
	assign rd_en     = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rd_ptr_q];

	// command queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/srr_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module srr_div import srr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  srr_div_req_t req,
	output srr_div_rsp_t rsp
);

	logic [31:0] rem_q, quo_q, div_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] shifted, diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, div_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/srr_back.sv -----
// back end: motor state, set handling, per-tick ramp and timer setting sequence
module srr_back import srr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  srr_cfg_t     cfg,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  srr_cmd_t     cmd,
	output srr_div_req_t div_req,
	input  srr_div_rsp_t div_rsp,
	output logic         res_push,
	input  logic         res_full,
	output srr_result_t  res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAMP,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [MOTOR_W-1:0] motor_q;
	logic [RATE_W-1:0]  target_q  [NUM_MOTORS];
	logic [1:0]         req_dir_q [NUM_MOTORS];
	logic [RATE_W-1:0]  cur_rate_q[NUM_MOTORS];
	logic               cur_dir_q [NUM_MOTORS];
	logic [RATE_W-1:0]  next_q;
	logic [PSC_W-1:0]   psc_q;
	logic               dir_q;
	logic [31:0]        divisor_q, reload_q;
	logic               start_q;

	logic [MOTOR_W-1:0] rd_idx;
	logic [RATE_W-1:0]  tgt_rd, cur_rd, tgt_eff, next_c;
	logic [1:0]         req_rd, rot_res;
	logic               dir_rd, dir_new;
	logic [RATE_W:0]    up_lim, down_lim;
	logic [PSC_W-1:0]   psc_c;
	logic               last_motor;

	// one shared read port into the motor state
	assign rd_idx = (state_q == ST_IDLE) ? cmd.motor : motor_q;
	assign tgt_rd = target_q[rd_idx];
	assign cur_rd = cur_rate_q[rd_idx];
	assign req_rd = req_dir_q[rd_idx];
	assign dir_rd = cur_dir_q[rd_idx];

	// toggle resolves against the rotation in effect now
	assign rot_res = (cmd.rot == ROT_TOGGLE) ? {1'b0, ~dir_rd} : cmd.rot;

	// ramp step toward the effective target
	always_comb begin
		if (req_rd != ROT_RETAIN && req_rd[0] != dir_rd) begin
			tgt_eff = '0;
		end else begin
			tgt_eff = tgt_rd;
		end
		up_lim   = {1'b0, cur_rd} + {5'b0, cfg.accel_step};
		down_lim = {1'b0, tgt_eff} + {5'b0, cfg.decel_step};
		if (cfg.no_ramp_mask[motor_q]) begin
			next_c = tgt_eff;
		end else if ({1'b0, tgt_eff} > up_lim) begin
			next_c = up_lim[RATE_W-1:0];
		end else if (down_lim < {1'b0, cur_rd}) begin
			next_c = cur_rd - cfg.decel_step;
		end else begin
			next_c = tgt_eff;
		end
		dir_new = (next_c == '0 && req_rd != ROT_RETAIN) ? req_rd[0] : dir_rd;
	end

	// decade prescaler choice
	always_comb begin
		if (next_c >= THR_1000) begin
			psc_c = PSC_2;
		end else if (next_c >= THR_100) begin
			psc_c = PSC_20;
		end else if (next_c >= THR_10) begin
			psc_c = PSC_200;
		end else if (next_c >= THR_1) begin
			psc_c = PSC_2000;
		end else begin
			psc_c = '0;
		end
	end

	assign last_motor = (motor_q == MOTOR_W'(NUM_MOTORS - 1));
	assign cmd_ready  = (state_q == ST_IDLE);

	assign div_req.start    = start_q;
	assign div_req.dividend = cfg.timer_clock;
	assign div_req.divisor  = divisor_q;

	// result beat
	assign res_push               = (state_q == ST_EMIT) && !res_full;
	assign res.out_motor          = motor_q;
	assign res.dir_level          = dir_q;
	assign res.drive_on           = (next_q != '0);
	assign res.prescale_minus_one = (psc_q == '0) ? '0 : psc_q - 1'b1;
	assign res.reload_value       = reload_q;
	assign res.compare_value      = reload_q[31:1];
	assign res.rate_now           = next_q;
	assign res.last               = last_motor;

	// sequencer with motor state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			motor_q   <= '0;
			start_q   <= 1'b0;
			next_q    <= '0;
			psc_q     <= '0;
			dir_q     <= 1'b0;
			divisor_q <= '0;
			reload_q  <= '0;
			for (int m = 0; m < NUM_MOTORS; m++) begin
				target_q[m]   <= '0;
				cur_rate_q[m] <= '0;
				req_dir_q[m]  <= {1'b0, INVERT_MASK_RST[m]};
				cur_dir_q[m]  <= INVERT_MASK_RST[m];
			end
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.is_tick) begin
							motor_q <= '0;
							state_q <= ST_RAMP;
						end else begin
							target_q[cmd.motor]  <= cmd.rate;
							req_dir_q[cmd.motor] <= rot_res;
						end
					end
				end
				ST_RAMP: begin
					cur_rate_q[motor_q] <= next_c;
					cur_dir_q[motor_q]  <= dir_new;
					next_q              <= next_c;
					psc_q               <= psc_c;
					dir_q               <= dir_new;
					state_q             <= ST_MUL;
				end
				ST_MUL: begin
					divisor_q <= 32'(psc_q) * 32'(next_q);
					if (psc_q == '0) begin
						reload_q <= '0;
						state_q  <= ST_EMIT;
					end else begin
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						reload_q <= div_rsp.quotient;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						if (last_motor) begin
							state_q <= ST_IDLE;
						end else begin
							motor_q <= motor_q + 1'b1;
							state_q <= ST_RAMP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/srr_outq.sv -----
// result queue between the back end and the pop side
module srr_outq import srr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  srr_result_t wr_data,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output srr_result_t rd_data
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	srr_result_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             wr_en, rd_en;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_en   = wr && !full;
	assign rd_en   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/stepper_rate_ramp_timer_core.sv -----
// Four-channel stepper ramp generator. Push a set beat (func 0) to store a
// target rate and rotation for one motor, or a tick beat (func 1) to ramp all
// motors one step and get four timer settings, motor 0 first, last set on
// motor 3. Each motor's reload value comes from the one-bit-per-cycle reload
// divider that the motors share; a motor at rate zero skips the divider, and
// a full result queue stalls the sequence. The back end takes no new command
// until the last setting of a tick is queued. A two-entry command queue in
// front and a four-entry result queue behind let input and output stall
// independently. Write configuration only while the block is idle.
`include "stepper_rate_ramp_timer_core_defines.svh"

module stepper_rate_ramp_timer_core import srr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  srr_item_t   item,
	output logic        empty,
	input  logic        pop,
	output srr_result_t result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	srr_cfg_t     cfg_q;
	logic         cmd_valid, cmd_ready;
	srr_cmd_t     cmd;
	srr_div_req_t div_req;
	srr_div_rsp_t div_rsp;
	logic         res_push, res_full;
	srr_result_t  res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_step   <= ACCEL_STEP_RST;
			cfg_q.decel_step   <= DECEL_STEP_RST;
			cfg_q.no_ramp_mask <= NO_RAMP_MASK_RST;
			cfg_q.invert_mask  <= INVERT_MASK_RST;
			cfg_q.timer_clock  <= TIMER_CLOCK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACCEL_STEP:   cfg_q.accel_step   <= cfg_data[15:0];
				CFG_DECEL_STEP:   cfg_q.decel_step   <= cfg_data[15:0];
				CFG_NO_RAMP_MASK: cfg_q.no_ramp_mask <= cfg_data[3:0];
				CFG_INVERT_MASK:  cfg_q.invert_mask  <= cfg_data[3:0];
				CFG_TIMER_CLOCK:  cfg_q.timer_clock  <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	srr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	srr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	srr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_push  (res_push),
		.res_full  (res_full),
		.res       (res)
	);

	srr_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_data (res),
		.full    (res_full),
		.empty   (empty),
		.pop     (pop),
		.rd_data (result)
	);

	// checks on result beats and on the divider handshake
	`SRR_ASSERT_NOW(a_last_motor, !empty && result.last, result.out_motor == 2'(NUM_MOTORS - 1), "last beat not on final motor")
	`SRR_ASSERT_NOW(a_off_zero, !empty && !result.drive_on, result.reload_value == '0 && result.compare_value == '0 && result.prescale_minus_one == '0 && result.rate_now == '0, "stopped motor carries timer setting")
	`SRR_ASSERT_NOW(a_half_reload, !empty, result.compare_value == result.reload_value[31:1], "compare not half of reload")
	`SRR_ASSERT_NEXT(a_div_busy, div_req.start, !div_rsp.done, "divider done right after start")

endmodule
